### hw/rtl/assert_macros.svh
// Assertion macros used by the generator controller RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### hw/rtl/lcg48_pkg.sv
// Types and constants of the 48-bit LCG random generator.
`timescale 1ns / 1ps
package lcg48_pkg;

  localparam int unsigned StateW = 48;
  localparam logic [34:0] LcgMult = 35'h5DEECE66D;
  localparam logic [47:0] LcgInc = 48'hB;

  typedef enum logic [2:0] {
    MODE_RESEED  = 3'd0,
    MODE_BITS    = 3'd1,
    MODE_LONG    = 3'd2,
    MODE_FRAC    = 3'd3,
    MODE_BOUNDED = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_STEP,
    ST_USE,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic reseed;
    logic step_run;
    logic save_hi;
    logic div_start;
    logic div_run;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       bound_bad;
    logic       bound_pow2;
    logic       step_done;
    logic       div_done;
    logic       reject;
  } dp_status_t;

endpackage

### hw/rtl/lcg48_dp.sv
// Datapath: LCG state, digit-serial multiply, remainder unit and result register.
`timescale 1ns / 1ps
module lcg48_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcg48_pkg::dp_cmd_t   cmd_i,
  output lcg48_pkg::dp_status_t status_o,
  input  logic [2:0]           mode_i,
  input  logic [47:0]          seed_in_i,
  input  logic [5:0]           bit_count_i,
  input  logic [31:0]          bound_i,
  output logic [63:0]          value_o,
  output logic                 bad_bound_o
);

  logic [2:0]  mode_q;
  logic [47:0] seed_q;
  logic [5:0]  cnt_q;
  logic [31:0] bound_q;

  logic [47:0] state_q;
  logic [47:0] acc_q;
  logic [47:0] prod_q, prod_d;
  logic [1:0]  mcnt_q;
  logic [15:0] digit;
  logic [50:0] mul_full;
  logic        step_done;

  logic [31:0] hi_q;

  logic [30:0] rem_q, rem_d;
  logic [30:0] quo_q;
  logic [4:0]  dcnt_q;
  logic [31:0] rem_trial;
  logic        div_done;

  logic [30:0] draw31;
  logic [30:0] bound_m1;
  logic [32:0] rej_sum;
  logic        bound_bad;
  logic        bound_pow2;

  logic [5:0]  bits_k;
  logic [5:0]  bits_sh;
  logic [63:0] pow_prod;
  logic [63:0] value_d;
  logic [63:0] value_q;
  logic        bad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q  <= mode_i;
      seed_q  <= seed_in_i;
      cnt_q   <= bit_count_i;
      bound_q <= bound_i;
    end
  end

  // one 16-bit digit of the state against the multiplier constant per cycle
  always_comb begin
    unique case (mcnt_q)
      2'd0:    digit = state_q[15:0];
      2'd1:    digit = state_q[31:16];
      2'd2:    digit = state_q[47:32];
      default: digit = 16'd0;
    endcase
  end

  assign mul_full = {35'd0, digit} * {16'd0, lcg48_pkg::LcgMult};

  always_comb begin
    unique case (mcnt_q)
      2'd0:    prod_d = mul_full[47:0];
      2'd1:    prod_d = {mul_full[31:0], 16'd0};
      2'd2:    prod_d = {mul_full[15:0], 32'd0};
      default: prod_d = 48'd0;
    endcase
  end

  assign step_done = cmd_i.step_run && (mcnt_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcg48_pkg::StateW'(lcg48_pkg::LcgMult);
      acc_q   <= lcg48_pkg::LcgInc;
      prod_q  <= 48'd0;
      mcnt_q  <= 2'd0;
    end else begin
      if (cmd_i.reseed) begin
        state_q <= seed_q ^ lcg48_pkg::StateW'(lcg48_pkg::LcgMult);
      end
      if (cmd_i.step_run) begin
        if (step_done) begin
          // last partial product lands; rearm for the next step
          state_q <= acc_q + prod_q;
          acc_q   <= lcg48_pkg::LcgInc;
          prod_q  <= 48'd0;
          mcnt_q  <= 2'd0;
        end else begin
          acc_q  <= acc_q + prod_q;
          prod_q <= prod_d;
          mcnt_q <= mcnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_hi) begin
      hi_q <= state_q[47:16];
    end
  end

  // restoring remainder, one quotient bit per cycle
  assign draw31    = state_q[47:17];
  assign rem_trial = {rem_q, quo_q[30]};
  assign rem_d     = (rem_trial >= {1'b0, bound_q[30:0]})
                     ? 31'(rem_trial - {1'b0, bound_q[30:0]}) : rem_trial[30:0];
  assign div_done  = cmd_i.div_run && (dcnt_q == 5'd30);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= 31'd0;
      quo_q  <= draw31;
      dcnt_q <= 5'd0;
    end else if (cmd_i.div_run) begin
      rem_q  <= rem_d;
      quo_q  <= {quo_q[29:0], 1'b0};
      dcnt_q <= dcnt_q + 5'd1;
    end
  end

  assign bound_m1   = 31'(bound_q - 32'd1);
  assign rej_sum    = {2'b0, draw31} - {2'b0, rem_q} + {2'b0, bound_m1};
  assign bound_bad  = (bound_q == 32'd0) || bound_q[31];
  assign bound_pow2 = ((bound_q & (bound_q - 32'd1)) == 32'd0);

  // clamp the bit count to 1..32
  always_comb begin
    priority if (cnt_q == 6'd0) begin
      bits_k = 6'd1;
    end else if (cnt_q > 6'd32) begin
      bits_k = 6'd32;
    end else begin
      bits_k = cnt_q;
    end
  end

  assign bits_sh  = 6'd48 - bits_k;
  assign pow_prod = {32'd0, bound_q} * {33'd0, draw31};

  always_comb begin
    unique case (mode_q)
      lcg48_pkg::MODE_BITS:  value_d = 64'(state_q >> bits_sh);
      lcg48_pkg::MODE_LONG:  value_d = {hi_q, 32'd0}
                                       + {{32{state_q[47]}}, state_q[47:16]};
      lcg48_pkg::MODE_FRAC:  value_d = {11'd0, hi_q[31:6], state_q[47:21]};
      lcg48_pkg::MODE_BOUNDED: begin
        priority if (bound_bad) begin
          value_d = 64'd0;
        end else if (bound_pow2) begin
          value_d = {31'd0, pow_prod[63:31]};
        end else begin
          value_d = {33'd0, rem_q};
        end
      end
      default: value_d = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      value_q <= value_d;
      bad_q   <= (mode_q == lcg48_pkg::MODE_BOUNDED) && bound_bad;
    end
  end

  assign value_o     = value_q;
  assign bad_bound_o = bad_q;

  assign status_o.mode       = mode_q;
  assign status_o.bound_bad  = bound_bad;
  assign status_o.bound_pow2 = bound_pow2;
  assign status_o.step_done  = step_done;
  assign status_o.div_done   = div_done;
  assign status_o.reject     = |rej_sum[32:31];

endmodule

### hw/rtl/lcg48_ctrl.sv
// Controller: request sequencing and output beat handshake.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcg48_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  lcg48_pkg::dp_status_t status_i,
  output lcg48_pkg::dp_cmd_t    cmd_o
);

  lcg48_pkg::ctrl_state_e state_q, state_d;
  logic second_q, second_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lcg48_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    unique case (state_q)
      lcg48_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lcg48_pkg::ST_DECODE;
        end
      end
      lcg48_pkg::ST_DECODE: begin
        second_d = 1'b0;
        unique case (status_i.mode)
          lcg48_pkg::MODE_BITS,
          lcg48_pkg::MODE_LONG,
          lcg48_pkg::MODE_FRAC: state_d = lcg48_pkg::ST_STEP;
          lcg48_pkg::MODE_BOUNDED: begin
            state_d = status_i.bound_bad ? lcg48_pkg::ST_DONE : lcg48_pkg::ST_STEP;
          end
          default: state_d = lcg48_pkg::ST_IDLE;
        endcase
      end
      lcg48_pkg::ST_STEP: begin
        if (status_i.step_done) begin
          state_d = lcg48_pkg::ST_USE;
        end
      end
      lcg48_pkg::ST_USE: begin
        unique case (status_i.mode)
          lcg48_pkg::MODE_LONG,
          lcg48_pkg::MODE_FRAC: begin
            if (second_q) begin
              state_d = lcg48_pkg::ST_DONE;
            end else begin
              second_d = 1'b1;
              state_d  = lcg48_pkg::ST_STEP;
            end
          end
          lcg48_pkg::MODE_BOUNDED: begin
            state_d = status_i.bound_pow2 ? lcg48_pkg::ST_DONE : lcg48_pkg::ST_DIV;
          end
          default: state_d = lcg48_pkg::ST_DONE;
        endcase
      end
      lcg48_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = lcg48_pkg::ST_CHECK;
        end
      end
      lcg48_pkg::ST_CHECK: begin
        // redraw when the draw falls in the biased tail
        state_d = status_i.reject ? lcg48_pkg::ST_STEP : lcg48_pkg::ST_DONE;
      end
      lcg48_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lcg48_pkg::ST_IDLE;
        end
      end
      default: state_d = lcg48_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = (state_q == lcg48_pkg::ST_IDLE) && in_valid_i;
    cmd_o.reseed    = (state_q == lcg48_pkg::ST_DECODE)
                      && (status_i.mode == lcg48_pkg::MODE_RESEED);
    cmd_o.step_run  = (state_q == lcg48_pkg::ST_STEP);
    cmd_o.save_hi   = (state_q == lcg48_pkg::ST_USE) && !second_q;
    cmd_o.div_start = (state_q == lcg48_pkg::ST_USE)
                      && (status_i.mode == lcg48_pkg::MODE_BOUNDED);
    cmd_o.div_run   = (state_q == lcg48_pkg::ST_DIV);
    cmd_o.load_out  = (state_q == lcg48_pkg::ST_DONE) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcg48_pkg::ST_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_PROP(a_load_out_free, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")
  `ASSERT_PROP(a_accept_decode, (in_valid_i && in_ready_o) |=> (state_q == lcg48_pkg::ST_DECODE), "accept lost")
  `ASSERT_NEVER(a_step_outside, status_i.step_done && (state_q != lcg48_pkg::ST_STEP), "stray step")
  `ASSERT_NEVER(a_div_outside, status_i.div_done && (state_q != lcg48_pkg::ST_DIV), "stray divide")

endmodule

### hw/rtl/lcg48_random_generator_unit.sv
// Top level of the 48-bit LCG random generator.
//
// Each input beat is one request: reseed, a 1..32 bit draw, a 64-bit draw, a 53-bit fraction
// or a bounded integer. An LCG step runs on a shared 16x35 multiplier that works through the
// state one 16-bit digit per cycle and adds the last partial product in a final step. A single
// draw (bits draw or power-of-two bound) takes one LCG step before its result beat is loaded,
// and a double draw (64-bit draw or fraction) takes two. A bounded integer with a bound that
// is not a power of two adds a bit-serial remainder and a tail check after the step, and each
// draw in the biased tail is redrawn with a new step. A bound that is not positive gives its
// flagged beat without a draw. The input is ready again in the cycle after the result is
// loaded. Reseed and unused mode codes go back to idle from decode and give no result. The
// block takes one request at a time; a finished result waits in the output register while the
// next request is accepted, and a request that finishes while that register is still full
// holds until the waiting beat is taken.
`timescale 1ns / 1ps
module lcg48_random_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // seed_in[47:0], bit_count[53:48], bound[85:54]
  input  logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // value[63:0]
  output logic        m_axis_tuser    // bad_bound[0]
);

  lcg48_pkg::dp_cmd_t    cmd;
  lcg48_pkg::dp_status_t status;

  lcg48_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcg48_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (s_axis_tuser),
    .seed_in_i   (s_axis_tdata[47:0]),
    .bit_count_i (s_axis_tdata[53:48]),
    .bound_i     (s_axis_tdata[85:54]),
    .value_o     (m_axis_tdata),
    .bad_bound_o (m_axis_tuser)
  );

endmodule

### test/lcg48_random_generator_unit_tb.sv
// Self-checking testbench for the 48-bit LCG random generator unit.
`timescale 1ns / 1ps
module lcg48_random_generator_unit_tb;

  localparam int unsigned ClkHalf = 6;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned MaxReports = 10;
  localparam logic [2:0] ModeUnusedFirst = 3'd5;
  localparam logic [2:0] ModeUnusedMid = 3'd6;
  localparam logic [2:0] ModeUnusedLast = 3'd7;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
  } draw_result_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [47:0] seed;
    logic [5:0]  count;
    logic [31:0] bound;
    logic        fixed;      // expectation typed in below, not predicted
    logic [63:0] value;
    logic        bad_bound;
  } stim_row_t;

  localparam int unsigned NumRows = 25;
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd32, 32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd1,  32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd0,  32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd63, 32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd33, 32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_LONG,    48'h0, 6'd0,  32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_FRAC,    48'h0, 6'd0,  32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h1, 1'b1, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h4000_0000, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h0, 1'b1, 64'h0, 1'b1},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'hFFFF_FFFF, 1'b1, 64'h0, 1'b1},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h8000_0000, 1'b1, 64'h0, 1'b1},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h4000_0001, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BOUNDED, 48'h0, 6'd0,  32'h3, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_RESEED,  48'h0, 6'd0,  32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd32, 32'h0, 1'b0, 64'h0, 1'b0},
    // seed equal to the multiplier clears the state, so the next step is just the increment
    '{lcg48_pkg::MODE_RESEED,  48'h5_DEEC_E66D, 6'd0, 32'h0, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_BITS,    48'h0, 6'd32, 32'h0, 1'b1, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_RESEED,  48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_LONG,    48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
    '{ModeUnusedFirst, 48'h0, 6'd1, 32'h5, 1'b0, 64'h0, 1'b0},
    '{ModeUnusedMid,   48'h1234_5678_9ABC, 6'd20, 32'h7, 1'b0, 64'h0, 1'b0},
    '{ModeUnusedLast,  48'hFFFF_FFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
    '{lcg48_pkg::MODE_FRAC,    48'h0, 6'd0,  32'h0, 1'b0, 64'h0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // seed_in[47:0], bit_count[53:48], bound[85:54]
  logic [2:0]  s_axis_tuser;   // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // value[63:0]
  logic        m_axis_tuser;   // bad_bound[0]

  logic [47:0]  gen_state;
  draw_result_t pending_draws [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sent_count;
  int unsigned  ready_hold = 0;

  lcg48_random_generator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Advance the LCG and return its top k bits.
  function automatic logic [63:0] draw_top(input int unsigned k);
    gen_state = gen_state * lcg48_pkg::LcgMult + lcg48_pkg::LcgInc;
    return 64'(gen_state >> (lcg48_pkg::StateW - k));
  endfunction

  // Work out what one request yields; returns 0 when it yields nothing.
  function automatic bit predict_draw(input logic [2:0] mode, input logic [47:0] seed,
                                      input logic [5:0] count, input logic [31:0] bound,
                                      output draw_result_t res);
    int unsigned k;
    logic [63:0] hi, lo, u, r, m;
    res = '0;
    unique case (mode)
      lcg48_pkg::MODE_RESEED: begin
        gen_state = seed ^ 48'(lcg48_pkg::LcgMult);
        return 1'b0;
      end
      lcg48_pkg::MODE_BITS: begin
        k = (count == 6'd0) ? 1 : (count > 6'd32) ? 32 : int'(count);
        res.value = draw_top(k);
      end
      lcg48_pkg::MODE_LONG: begin
        hi = draw_top(32);
        lo = draw_top(32);
        res.value = (hi << 32) + {{32{lo[31]}}, lo[31:0]};
      end
      lcg48_pkg::MODE_FRAC: begin
        hi = draw_top(26);
        lo = draw_top(27);
        res.value = (hi << 27) + lo;
      end
      lcg48_pkg::MODE_BOUNDED: begin
        if (bound == 32'h0 || bound[31]) begin
          res.bad_bound = 1'b1;
        end else if ((bound & (bound - 32'd1)) == 32'h0) begin
          u = draw_top(31);
          res.value = (64'(bound) * u) >> 31;
        end else begin
          m = 64'(bound) - 64'd1;
          // redraw while the draw falls in the biased tail
          do begin
            u = draw_top(31);
            r = u % 64'(bound);
          end while (u - r + m > 64'h7FFF_FFFF);
          res.value = r;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pct;
    // every third stretch of 60 beats runs back to back
    if ((sent_count / 60) % 3 == 1) return 0;
    pct = $urandom_range(0, 99);
    if (pct < 55) return 0;
    if (pct < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 45);
  endfunction

  task automatic push_request(input logic [2:0] mode, input logic [47:0] seed,
                              input logic [5:0] count, input logic [31:0] bound,
                              input bit fixed, input draw_result_t fixed_res);
    int unsigned gap;
    draw_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, bound, count, seed};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if (predict_draw(mode, seed, count, bound, res))
      pending_draws.push_back(fixed ? fixed_res : res);
  endtask

  function automatic logic [2:0] pick_mode();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 7)  return lcg48_pkg::MODE_RESEED;
    if (pct < 30) return lcg48_pkg::MODE_BITS;
    if (pct < 45) return lcg48_pkg::MODE_LONG;
    if (pct < 60) return lcg48_pkg::MODE_FRAC;
    if (pct < 95) return lcg48_pkg::MODE_BOUNDED;
    return 3'($urandom_range(ModeUnusedFirst, ModeUnusedLast));
  endfunction

  function automatic logic [31:0] pick_bound();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 35) return $urandom_range(2, 1000);
    if (pct < 50) return 32'h1 << $urandom_range(0, 30);
    // upper half of the range rejects often
    if (pct < 68) return 32'h4000_0000 + $urandom_range(1, 32'h3FFF_FFFF);
    if (pct < 90) return $urandom & 32'h7FFF_FFFF;
    if (pct < 94) return 32'h0;
    return $urandom;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch %0s at cycle %0d: expected %h, got %h", what, cycle_count, exp_v,
               act_v);
  endtask

  // Receiver: accept most beats, stall now and then, with stall-free stretches.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if ((cycle_count / 2500) % 3 == 2 || $urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 50);
      m_axis_tready <= 1'b0;
    end
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    draw_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_draws.size() == 0) begin
        note_mismatch("unexpected beat", 64'h0, m_axis_tdata);
      end else begin
        exp_res = pending_draws.pop_front();
        if (m_axis_tdata !== exp_res.value)
          note_mismatch("value", exp_res.value, m_axis_tdata);
        if (m_axis_tuser !== exp_res.bad_bound)
          note_mismatch("bad_bound", 64'(exp_res.bad_bound), 64'(m_axis_tuser));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    logic [2:0] mode;
    logic [5:0] count;
    draw_result_t fixed_res;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    gen_state     = 48'(lcg48_pkg::LcgMult);
    sent_count    = 0;
    counted       = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      fixed_res.value     = DirectedRows[i].value;
      fixed_res.bad_bound = DirectedRows[i].bad_bound;
      push_request(DirectedRows[i].mode, DirectedRows[i].seed, DirectedRows[i].count,
                   DirectedRows[i].bound, DirectedRows[i].fixed, fixed_res);
    end

    while (counted < RandomItems) begin
      mode  = pick_mode();
      count = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(1, 32)) :
                                             6'($urandom_range(0, 63));
      push_request(mode, 48'({$urandom, $urandom}), count, pick_bound(), 1'b0, '0);
      if (mode < ModeUnusedFirst) counted++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
